/* src/mwpo_pkg.sv */
// Shared types, constants and the sine table generator for the phase oscillator.
package mwpo_pkg;

	// Default sizes of the phase accumulator, sine table and output samples.
	localparam int PHASE_BITS_DEF      = 32;
	localparam int SINE_TABLE_BITS_DEF = 10;
	localparam int SAMPLE_BITS_DEF     = 16;

	// Configuration port and register widths.
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 32;
	localparam int STEP_BITS      = 32;
	localparam int WAVE_BITS      = 3;
	localparam int AMP_BITS       = 16;
	localparam int PAN_BITS       = 16;
	localparam int NOISE_BITS     = 32;

	// Fraction bits of the Q1.15 gain and pan factors.
	localparam int FRAC_BITS = 15;

	// Register indexes.
	localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_STEP = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_WAVEFORM   = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_AMPLITUDE  = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PAN        = 2'd3;

	// Register reset values.
	localparam logic [STEP_BITS-1:0] RST_PHASE_STEP = 32'd42852281;
	localparam logic [WAVE_BITS-1:0] RST_WAVEFORM   = 3'd0;
	localparam logic [AMP_BITS-1:0]  RST_AMPLITUDE  = 16'd16384;
	localparam logic [PAN_BITS-1:0]  RST_PAN        = 16'd16384;

	// Waveform codes.
	localparam logic [WAVE_BITS-1:0] WAVE_SINE     = 3'd0;
	localparam logic [WAVE_BITS-1:0] WAVE_SAW      = 3'd1;
	localparam logic [WAVE_BITS-1:0] WAVE_SQUARE   = 3'd2;
	localparam logic [WAVE_BITS-1:0] WAVE_TRIANGLE = 3'd3;
	localparam logic [WAVE_BITS-1:0] WAVE_NOISE    = 3'd4;

	// Full right pan, which is also unity for the left factor.
	localparam logic [PAN_BITS-1:0] PAN_FULL = 16'd32768;

	// Noise generator seed and Galois toggle mask.
	localparam logic [NOISE_BITS-1:0] NOISE_SEED = 32'hACE1ACE1;
	localparam logic [NOISE_BITS-1:0] NOISE_TAPS = 32'h80200003;

	// Operand pairs of the shared multiplier.
	typedef enum logic [1:0] {
		MUL_GAIN,
		MUL_LEFT,
		MUL_RIGHT
	} mul_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     accept;
		logic     rom_rd;
		logic     wave_ld;
		logic     mul_ld;
		mul_sel_t mul_sel;
		logic     gain_ld;
		logic     left_ld;
		logic     out_ld;
	} cmd_t;

	// One quarter-wave sine entry, scaled to the sample full scale. Evaluated at
	// elaboration only: a Q30 Taylor series of seven terms, clamped and rounded.
	function automatic logic [63:0] sine_entry(input int unsigned k,
		input int unsigned tbits, input int unsigned sbits);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] full;
		longint      sum;
		int unsigned n;
		x    = (64'(k) * 64'd1686629713) >> tbits;
		x2   = (x * x) >> 30;
		term = x;
		sum  = longint'(x);
		for (n = 1; n <= 6; n++) begin
			term = (term * x2) >> 30;
			case (n)
				1: term = term / 64'd6;
				2: term = term / 64'd20;
				3: term = term / 64'd42;
				4: term = term / 64'd72;
				5: term = term / 64'd110;
				default: term = term / 64'd156;
			endcase
			if (n % 2 == 1) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		if (sum > (64'sd1 <<< 30)) begin
			sum = 64'sd1 <<< 30;
		end
		full = (64'd1 << (sbits - 1)) - 64'd1;
		return (64'(sum) * full + (64'd1 << 29)) >> 30;
	endfunction

endpackage

/* src/mwpo_ctrl.sv */
// Controller state machine that sequences one request through the datapath.
module mwpo_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output mwpo_pkg::cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ROM,
		S_WAVE,
		S_MULG,
		S_GAIN,
		S_MULL,
		S_MULR,
		S_PUSH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   push;

	// The finished result moves to the output register once that is free.
	assign push      = (state_q == S_PUSH) && (!out_valid_q || !out_stall);
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	// State and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_ROM;
				S_ROM:  state_q <= S_WAVE;
				S_WAVE: state_q <= S_MULG;
				S_MULG: state_q <= S_GAIN;
				S_GAIN: state_q <= S_MULL;
				S_MULL: state_q <= S_MULR;
				S_MULR: state_q <= S_PUSH;
				S_PUSH: if (push) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Command decode from the current state.
	always_comb begin
		cmd         = '0;
		cmd.mul_sel = mwpo_pkg::MUL_GAIN;
		unique case (state_q)
			S_IDLE: cmd.accept = in_valid;
			S_ROM:  cmd.rom_rd = 1'b1;
			S_WAVE: cmd.wave_ld = 1'b1;
			S_MULG: begin
				cmd.mul_ld  = 1'b1;
				cmd.mul_sel = mwpo_pkg::MUL_GAIN;
			end
			S_GAIN: cmd.gain_ld = 1'b1;
			S_MULL: begin
				cmd.mul_ld  = 1'b1;
				cmd.mul_sel = mwpo_pkg::MUL_LEFT;
			end
			S_MULR: begin
				cmd.left_ld = 1'b1;
				cmd.mul_ld  = 1'b1;
				cmd.mul_sel = mwpo_pkg::MUL_RIGHT;
			end
			S_PUSH: cmd.out_ld = push;
			default: cmd = '0;
		endcase
	end

`ifndef SYNTHESIS
	// An accepted request always starts with the table read.
	a_accept_to_rom: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> state_q == S_ROM)
		else $error("accepted request did not start the table read");

	// A result is never loaded over one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> (!out_valid_q || !out_stall))
		else $error("pending result overwritten");

	// The last step is left only by handing the result over.
	a_push_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PUSH && !push) |=> state_q == S_PUSH)
		else $error("final step left without a result load");

	// Output valid rises only after a result load.
	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_PUSH)
		else $error("output valid rose without a result load");
`endif

endmodule

/* src/mwpo_dp.sv */
// Datapath: configuration registers, phase and noise state, sine table, shared multiplier.
module mwpo_dp #(
	parameter int PHASE_BITS      = mwpo_pkg::PHASE_BITS_DEF,
	parameter int SINE_TABLE_BITS = mwpo_pkg::SINE_TABLE_BITS_DEF,
	parameter int SAMPLE_BITS     = mwpo_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  mwpo_pkg::cmd_t                         cmd,
	input  logic                                   advance,
	input  logic                                   cfg_en,
	input  logic [mwpo_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [mwpo_pkg::CFG_DATA_BITS-1:0]     cfg_data,
	output logic signed [SAMPLE_BITS-1:0]          left_sample,
	output logic signed [SAMPLE_BITS-1:0]          right_sample
);

	localparam int QUARTER_LEN = 2 ** SINE_TABLE_BITS;
	localparam int ADDR_BITS   = SINE_TABLE_BITS + 1;
	localparam int ENTRY_BITS  = SAMPLE_BITS - 1;
	localparam int WIDE_BITS   = SAMPLE_BITS + 3;
	localparam int GAIN_BITS   = SAMPLE_BITS + 1;
	localparam int FACTOR_BITS = mwpo_pkg::PAN_BITS + 1;
	localparam int PROD_BITS   = GAIN_BITS + FACTOR_BITS;
	localparam int EXT_BITS    = PHASE_BITS + SAMPLE_BITS + 1;
	localparam int STEP_WIDE   = PHASE_BITS + mwpo_pkg::STEP_BITS;

	localparam logic signed [WIDE_BITS-1:0] HALF       = WIDE_BITS'(2 ** (SAMPLE_BITS - 1));
	localparam logic signed [WIDE_BITS-1:0] THREE_HALF = WIDE_BITS'(3 * 2 ** (SAMPLE_BITS - 1));
	localparam logic signed [WIDE_BITS-1:0] SAT_HI     = HALF - WIDE_BITS'(1);
	localparam logic signed [WIDE_BITS-1:0] SAT_LO     = -HALF;
	localparam logic signed [SAMPLE_BITS-1:0] S_MAX    = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] S_MIN    = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

	// Clamp a widened intermediate to the signed sample range.
	function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [WIDE_BITS-1:0] v);
		if (v > SAT_HI) begin
			return S_MAX;
		end else if (v < SAT_LO) begin
			return S_MIN;
		end
		return v[SAMPLE_BITS-1:0];
	endfunction

	logic [mwpo_pkg::STEP_BITS-1:0]  step_q;
	logic [mwpo_pkg::WAVE_BITS-1:0]  wave_sel_q;
	logic [mwpo_pkg::AMP_BITS-1:0]   amp_q;
	logic [mwpo_pkg::PAN_BITS-1:0]   pan_q;
	logic [PHASE_BITS-1:0]           phase_q;
	logic [mwpo_pkg::NOISE_BITS-1:0] lfsr_q;
	logic [STEP_WIDE-1:0]            step_wide;
	logic [PHASE_BITS-1:0]           step_ext;
	logic [EXT_BITS-1:0]             phase_ext;
	logic [SINE_TABLE_BITS+1:0]      sine_top;
	logic [1:0]                      quadrant;
	logic [SINE_TABLE_BITS-1:0]      sine_idx;
	logic [ADDR_BITS-1:0]            rom_addr;
	logic [ENTRY_BITS-1:0]           sine_rom [QUARTER_LEN+1];
	logic [ENTRY_BITS-1:0]           sine_q;
	logic signed [SAMPLE_BITS-1:0]   sine_pos;
	logic [SAMPLE_BITS-1:0]          saw_top;
	logic [SAMPLE_BITS:0]            tri_w;
	logic signed [WIDE_BITS-1:0]     saw_v;
	logic signed [WIDE_BITS-1:0]     tri_v;
	logic signed [SAMPLE_BITS-1:0]   wave_d;
	logic signed [SAMPLE_BITS-1:0]   wave_q;
	logic [mwpo_pkg::PAN_BITS-1:0]   pan_eff;
	logic signed [GAIN_BITS-1:0]     op_a;
	logic signed [FACTOR_BITS-1:0]   op_b;
	logic signed [PROD_BITS-1:0]     prod_d;
	logic signed [PROD_BITS-1:0]     prod_q;
	logic signed [WIDE_BITS-1:0]     prod_sh;
	logic signed [GAIN_BITS-1:0]     gain_q;
	logic signed [SAMPLE_BITS-1:0]   left_q;
	logic signed [SAMPLE_BITS-1:0]   left_out_q;
	logic signed [SAMPLE_BITS-1:0]   right_out_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q     <= mwpo_pkg::RST_PHASE_STEP;
			wave_sel_q <= mwpo_pkg::RST_WAVEFORM;
			amp_q      <= mwpo_pkg::RST_AMPLITUDE;
			pan_q      <= mwpo_pkg::RST_PAN;
		end else if (cfg_en) begin
			unique case (cfg_index)
				mwpo_pkg::REG_PHASE_STEP: step_q <= cfg_data[mwpo_pkg::STEP_BITS-1:0];
				mwpo_pkg::REG_WAVEFORM:   wave_sel_q <= cfg_data[mwpo_pkg::WAVE_BITS-1:0];
				mwpo_pkg::REG_AMPLITUDE:  amp_q <= cfg_data[mwpo_pkg::AMP_BITS-1:0];
				mwpo_pkg::REG_PAN:        pan_q <= cfg_data[mwpo_pkg::PAN_BITS-1:0];
				default: ;
			endcase
		end
	end

	// The tuning word is fitted to the accumulator width, wrapping modulo a full turn.
	assign step_wide = STEP_WIDE'(step_q);
	assign step_ext  = step_wide[PHASE_BITS-1:0];

	// Phase accumulator and noise register step on an advancing request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			lfsr_q  <= mwpo_pkg::NOISE_SEED;
		end else if (cmd.accept && advance) begin
			phase_q <= phase_q + step_ext;
			if (wave_sel_q == mwpo_pkg::WAVE_NOISE) begin
				lfsr_q <= (lfsr_q >> 1) ^ (lfsr_q[0] ? mwpo_pkg::NOISE_TAPS : '0);
			end
		end
	end

	// Phase padded below so the top n bits give floor(u * 2^n) for any n up to its width.
	assign phase_ext = {phase_q, {(SAMPLE_BITS + 1){1'b0}}};
	assign sine_top  = phase_ext[EXT_BITS-1 -: SINE_TABLE_BITS + 2];
	assign quadrant  = sine_top[SINE_TABLE_BITS+1:SINE_TABLE_BITS];
	assign sine_idx  = sine_top[SINE_TABLE_BITS-1:0];
	assign rom_addr  = quadrant[0] ? (ADDR_BITS'(QUARTER_LEN) - {1'b0, sine_idx})
		: {1'b0, sine_idx};

	// Quarter-wave sine table, fixed at elaboration.
	for (genvar k = 0; k <= QUARTER_LEN; k++) begin : g_rom
		assign sine_rom[k] = ENTRY_BITS'(mwpo_pkg::sine_entry(k, SINE_TABLE_BITS, SAMPLE_BITS));
	end

	// Registered table read.
	always_ff @(posedge clk) begin
		if (cmd.rom_rd) begin
			sine_q <= sine_rom[rom_addr];
		end
	end

	// Waveform selection.
	assign sine_pos = signed'({1'b0, sine_q});
	assign saw_top  = phase_ext[EXT_BITS-1 -: SAMPLE_BITS];
	assign tri_w    = phase_ext[EXT_BITS-1 -: SAMPLE_BITS + 1];
	assign saw_v    = HALF - signed'(WIDE_BITS'(saw_top));
	assign tri_v    = phase_q[PHASE_BITS-1] ? (signed'(WIDE_BITS'(tri_w)) - THREE_HALF)
		: (HALF - signed'(WIDE_BITS'(tri_w)));

	always_comb begin
		case (wave_sel_q)
			mwpo_pkg::WAVE_SINE:     wave_d = quadrant[1] ? -sine_pos : sine_pos;
			mwpo_pkg::WAVE_SAW:      wave_d = sat(saw_v);
			mwpo_pkg::WAVE_SQUARE:   wave_d = phase_q[PHASE_BITS-1] ? S_MAX : S_MIN;
			mwpo_pkg::WAVE_TRIANGLE: wave_d = sat(tri_v);
			mwpo_pkg::WAVE_NOISE:    wave_d = signed'(lfsr_q[mwpo_pkg::NOISE_BITS-1 -: SAMPLE_BITS]);
			default:                 wave_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wave_ld) begin
			wave_q <= wave_d;
		end
	end

	// Shared multiplier: gain first, then the left and right pan factors.
	assign pan_eff = (pan_q > mwpo_pkg::PAN_FULL) ? mwpo_pkg::PAN_FULL : pan_q;

	always_comb begin
		case (cmd.mul_sel)
			mwpo_pkg::MUL_GAIN: begin
				op_a = GAIN_BITS'(wave_q);
				op_b = signed'({1'b0, amp_q});
			end
			mwpo_pkg::MUL_LEFT: begin
				op_a = gain_q;
				op_b = signed'({1'b0, mwpo_pkg::PAN_FULL - pan_eff});
			end
			mwpo_pkg::MUL_RIGHT: begin
				op_a = gain_q;
				op_b = signed'({1'b0, pan_eff});
			end
			default: begin
				op_a = gain_q;
				op_b = '0;
			end
		endcase
	end

	assign prod_d = PROD_BITS'(op_a) * PROD_BITS'(op_b);

	// Arithmetic shift by the fraction width gives the floor of the Q1.15 product.
	assign prod_sh = prod_q[PROD_BITS-1:mwpo_pkg::FRAC_BITS];

	always_ff @(posedge clk) begin
		if (cmd.mul_ld) begin
			prod_q <= prod_d;
		end
		if (cmd.gain_ld) begin
			gain_q <= prod_sh[GAIN_BITS-1:0];
		end
		if (cmd.left_ld) begin
			left_q <= sat(prod_sh);
		end
		if (cmd.out_ld) begin
			left_out_q  <= left_q;
			right_out_q <= sat(prod_sh);
		end
	end

	assign left_sample  = left_out_q;
	assign right_sample = right_out_q;

endmodule

/* src/multi_waveform_phase_oscillator.sv */
// Top level of the stereo multi-waveform phase oscillator.
//
//   Channel  Signals                                          Direction  Moves
//   in       in_valid, in_stall, advance                      into block one request per sample
//   out      out_valid, out_stall, left_sample, right_sample  out        one stereo sample pair
//   cfg      cfg_en, cfg_index, cfg_data                      into block register write
//
// A result is loaded after the table read, waveform, gain and both pan steps, and a new
// request is taken only once the last is done; the single shared multiplier, used three
// times, and the registered sine table read set that pace. in_stall is high while the
// sequencer is busy. arst_n clears the sequencer, the phase, the noise seed and the
// registers to their reset values. While out_stall holds a result, the next request is
// still accepted and waits in its last step.
module multi_waveform_phase_oscillator #(
	parameter int PHASE_BITS      = mwpo_pkg::PHASE_BITS_DEF,
	parameter int SINE_TABLE_BITS = mwpo_pkg::SINE_TABLE_BITS_DEF,
	parameter int SAMPLE_BITS     = mwpo_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                advance,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [SAMPLE_BITS-1:0]       left_sample,
	output logic signed [SAMPLE_BITS-1:0]       right_sample,
	input  logic                                cfg_en,
	input  logic [mwpo_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [mwpo_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	mwpo_pkg::cmd_t cmd;

	// Sequencer.
	mwpo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// Arithmetic and state.
	mwpo_dp #(
		.PHASE_BITS      (PHASE_BITS),
		.SINE_TABLE_BITS (SINE_TABLE_BITS),
		.SAMPLE_BITS     (SAMPLE_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.advance      (advance),
		.cfg_en       (cfg_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.left_sample  (left_sample),
		.right_sample (right_sample)
	);

endmodule

/* tb/sv/mwpo_checker.sv */
// Checker that predicts and compares the stereo samples of the phase oscillator.
module mwpo_checker (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        in_valid,
	input  logic                                        in_stall,
	input  logic                                        advance,
	input  logic                                        out_valid,
	input  logic                                        out_stall,
	input  logic signed [mwpo_pkg::SAMPLE_BITS_DEF-1:0] left_sample,
	input  logic signed [mwpo_pkg::SAMPLE_BITS_DEF-1:0] right_sample,
	input  logic                                        cfg_en,
	input  logic [mwpo_pkg::CFG_INDEX_BITS-1:0]         cfg_index,
	input  logic [mwpo_pkg::CFG_DATA_BITS-1:0]          cfg_data,
	output int                                          fail_count,
	output int                                          pairs_seen,
	output int                                          pairs_pending
);

	localparam int     PBITS        = mwpo_pkg::PHASE_BITS_DEF;
	localparam int     TBITS        = mwpo_pkg::SINE_TABLE_BITS_DEF;
	localparam int     SBITS        = mwpo_pkg::SAMPLE_BITS_DEF;
	localparam int     ABITS        = TBITS + 1;
	localparam int     QLEN         = 1 << TBITS;
	localparam longint HALF         = longint'(1) << (SBITS - 1);
	localparam int     REPORT_LIMIT = 10;

	typedef struct packed {
		logic signed [SBITS-1:0] left;
		logic signed [SBITS-1:0] right;
	} stereo_t;

	// Quarter-wave sine magnitudes, scaled to the sample full scale.
	logic [SBITS-1:0] quarter_sine [0:QLEN];

	// Mirrored configuration and oscillator state.
	logic [mwpo_pkg::STEP_BITS-1:0]  step_reg;
	logic [mwpo_pkg::WAVE_BITS-1:0]  wave_reg;
	logic [mwpo_pkg::AMP_BITS-1:0]   amp_reg;
	logic [mwpo_pkg::PAN_BITS-1:0]   pan_reg;
	logic [PBITS-1:0]                phase;
	logic [mwpo_pkg::NOISE_BITS-1:0] lfsr;

	stereo_t expected_pairs [$];
	int      failures;

	// Build the quarter-wave table from a Q30 Taylor series of the sine.
	initial begin : build_quarter_sine
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		longint      acc;
		int unsigned k;
		int unsigned n;
		for (k = 0; k <= QLEN; k++) begin
			x    = (64'(k) * 64'd1686629713) >> TBITS;
			x2   = (x * x) >> 30;
			term = x;
			acc  = longint'(x);
			for (n = 1; n <= 6; n++) begin
				term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
				if (n % 2 == 1) begin
					acc -= longint'(term);
				end else begin
					acc += longint'(term);
				end
			end
			if (acc < 0) begin
				acc = 0;
			end
			if (acc > (longint'(1) << 30)) begin
				acc = longint'(1) << 30;
			end
			quarter_sine[k] = SBITS'((acc * (HALF - 1) + (longint'(1) << 29)) >>> 30);
		end
	end

	function automatic longint clamp_sample(input longint v);
		if (v > HALF - 1) begin
			return HALF - 1;
		end
		if (v < -HALF) begin
			return -HALF;
		end
		return v;
	endfunction

	// Raw waveform level for the current phase and noise register.
	function automatic longint wave_level();
		logic [TBITS+1:0] top;
		logic [1:0]       quadrant;
		logic [TBITS-1:0] idx;
		logic [ABITS-1:0] addr;
		longint           m;
		longint           w;
		case (wave_reg)
			mwpo_pkg::WAVE_SINE: begin
				top      = phase[PBITS-1 -: TBITS + 2];
				quadrant = top[TBITS+1:TBITS];
				idx      = top[TBITS-1:0];
				addr     = quadrant[0] ? (ABITS'(QLEN) - {1'b0, idx}) : {1'b0, idx};
				m        = longint'(quarter_sine[addr]);
				return quadrant[1] ? -m : m;
			end
			mwpo_pkg::WAVE_SAW: begin
				return clamp_sample(HALF - longint'(phase >> (PBITS - SBITS)));
			end
			mwpo_pkg::WAVE_SQUARE: begin
				return phase[PBITS-1] ? HALF - 1 : -HALF;
			end
			mwpo_pkg::WAVE_TRIANGLE: begin
				w = longint'(phase >> (PBITS - SBITS - 1));
				return clamp_sample(phase[PBITS-1] ? w - 3 * HALF : HALF - w);
			end
			mwpo_pkg::WAVE_NOISE: begin
				return longint'($signed(lfsr[mwpo_pkg::NOISE_BITS-1 -: SBITS]));
			end
			default: begin
				return 0;
			end
		endcase
	endfunction

	// Advance the oscillator for one request and form the stereo pair it yields.
	function automatic stereo_t next_pair(input logic adv);
		logic                          lsb;
		logic [mwpo_pkg::PAN_BITS-1:0] pan_eff;
		longint                        s;
		longint                        g;
		stereo_t                       res;
		if (adv) begin
			phase = phase + PBITS'(step_reg);
			if (wave_reg == mwpo_pkg::WAVE_NOISE) begin
				lsb  = lfsr[0];
				lfsr = lfsr >> 1;
				if (lsb) begin
					lfsr = lfsr ^ mwpo_pkg::NOISE_TAPS;
				end
			end
		end
		pan_eff   = (pan_reg > mwpo_pkg::PAN_FULL) ? mwpo_pkg::PAN_FULL : pan_reg;
		s         = wave_level();
		g         = (s * longint'(amp_reg)) >>> mwpo_pkg::FRAC_BITS;
		res.left  = SBITS'(clamp_sample((g * longint'(mwpo_pkg::PAN_FULL - pan_eff))
			>>> mwpo_pkg::FRAC_BITS));
		res.right = SBITS'(clamp_sample((g * longint'(pan_eff)) >>> mwpo_pkg::FRAC_BITS));
		return res;
	endfunction

	// Track register writes and requests, and compare every accepted sample pair.
	always @(posedge clk or negedge arst_n) begin
		stereo_t want;
		if (!arst_n) begin
			step_reg = mwpo_pkg::RST_PHASE_STEP;
			wave_reg = mwpo_pkg::RST_WAVEFORM;
			amp_reg  = mwpo_pkg::RST_AMPLITUDE;
			pan_reg  = mwpo_pkg::RST_PAN;
			phase    = '0;
			lfsr     = mwpo_pkg::NOISE_SEED;
			failures = 0;
			expected_pairs.delete();
			fail_count    <= 0;
			pairs_seen    <= 0;
			pairs_pending <= 0;
		end else begin
			if (cfg_en) begin
				case (cfg_index)
					mwpo_pkg::REG_PHASE_STEP: step_reg = cfg_data[mwpo_pkg::STEP_BITS-1:0];
					mwpo_pkg::REG_WAVEFORM:   wave_reg = cfg_data[mwpo_pkg::WAVE_BITS-1:0];
					mwpo_pkg::REG_AMPLITUDE:  amp_reg  = cfg_data[mwpo_pkg::AMP_BITS-1:0];
					mwpo_pkg::REG_PAN:        pan_reg  = cfg_data[mwpo_pkg::PAN_BITS-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (expected_pairs.size() == 0) begin
					if (failures < REPORT_LIMIT) begin
						$display("unexpected sample pair: left %0d right %0d",
							left_sample, right_sample);
					end
					failures++;
				end else begin
					want = expected_pairs.pop_front();
					if (want.left !== left_sample || want.right !== right_sample) begin
						if (failures < REPORT_LIMIT) begin
							$display({"sample pair %0d: expected left %0d right %0d, ",
								"got left %0d right %0d"},
								pairs_seen, want.left, want.right, left_sample, right_sample);
						end
						failures++;
					end
				end
				pairs_seen <= pairs_seen + 1;
			end
			if (in_valid && !in_stall) begin
				expected_pairs.push_back(next_pair(advance));
			end
			fail_count    <= failures;
			pairs_pending <= expected_pairs.size();
		end
	end

endmodule

/* tb/sv/tb.sv */
// Testbench top: drives the phase oscillator and its registers and gives the verdict.
module tb;

	localparam int HOLD_CYCLES    = 200;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 16;
	localparam int RANDOM_ITEMS   = 1000;
	localparam int CLEAN_TAIL     = 120;
	localparam int DATA_BITS      = mwpo_pkg::CFG_DATA_BITS;

	// Waveform codes that select no waveform.
	localparam logic [mwpo_pkg::WAVE_BITS-1:0] WAVE_UNUSED_LO = 3'd5;
	localparam logic [mwpo_pkg::WAVE_BITS-1:0] WAVE_UNUSED_HI = 3'd7;

	logic                                        clk;
	logic                                        arst_n;
	logic                                        in_valid;
	logic                                        in_stall;
	logic                                        advance;
	logic                                        out_valid;
	logic                                        out_stall;
	logic signed [mwpo_pkg::SAMPLE_BITS_DEF-1:0] left_sample;
	logic signed [mwpo_pkg::SAMPLE_BITS_DEF-1:0] right_sample;
	logic                                        cfg_en;
	logic [mwpo_pkg::CFG_INDEX_BITS-1:0]         cfg_index;
	logic [DATA_BITS-1:0]                        cfg_data;

	int   fail_count;
	int   pairs_seen;
	int   pairs_pending;
	int   requests_sent = 0;
	logic hold_req      = 1'b0;
	logic rx_calm       = 1'b0;

	multi_waveform_phase_oscillator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.advance      (advance),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.left_sample  (left_sample),
		.right_sample (right_sample),
		.cfg_en       (cfg_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	mwpo_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.advance       (advance),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.left_sample   (left_sample),
		.right_sample  (right_sample),
		.cfg_en        (cfg_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pairs_seen    (pairs_seen),
		.pairs_pending (pairs_pending)
	);

	// Free-running clock.
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Offer one request and hold it until the block takes it.
	task automatic offer(input logic adv);
		in_valid <= 1'b1;
		advance  <= adv;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		requests_sent++;
	endtask

	// Leave the request channel idle for a while.
	task automatic pause_sender(input int cycles);
		in_valid <= 1'b0;
		advance  <= 1'($urandom);
		repeat (cycles) @(posedge clk);
	endtask

	// Wait until every request has produced its sample pair, then let the block settle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pairs_seen != requests_sent) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all four registers once the block is idle.
	task automatic setup_voice(input logic [DATA_BITS-1:0] step_w, wave_w, amp_w, pan_w);
		wait_idle();
		cfg_en    <= 1'b1;
		cfg_index <= mwpo_pkg::REG_PHASE_STEP;
		cfg_data  <= step_w;
		@(posedge clk);
		cfg_index <= mwpo_pkg::REG_WAVEFORM;
		cfg_data  <= wave_w;
		@(posedge clk);
		cfg_index <= mwpo_pkg::REG_AMPLITUDE;
		cfg_data  <= amp_w;
		@(posedge clk);
		cfg_index <= mwpo_pkg::REG_PAN;
		cfg_data  <= pan_w;
		@(posedge clk);
		cfg_en    <= 1'b0;
	endtask

	// Pick a random setting, leaning on the extremes, with junk in the unused upper bits half of the time.
	task automatic random_voice();
		logic [DATA_BITS-1:0]          step_w;
		logic [DATA_BITS-1:0]          junk;
		logic [DATA_BITS-1:0]          pick;
		logic [mwpo_pkg::WAVE_BITS-1:0] wave;
		logic [mwpo_pkg::AMP_BITS-1:0]  amp;
		logic [mwpo_pkg::PAN_BITS-1:0]  pan;
		case ($urandom_range(0, 5))
			0:       step_w = $urandom_range(0, 255);
			1:       step_w = 32'h8000_0000;
			2:       step_w = 32'hFFFF_FFFF - $urandom_range(0, 3);
			default: step_w = $urandom;
		endcase
		if ($urandom_range(0, 9) == 0) begin
			pick = $urandom_range(WAVE_UNUSED_LO, WAVE_UNUSED_HI);
		end else begin
			pick = $urandom_range(mwpo_pkg::WAVE_SINE, mwpo_pkg::WAVE_NOISE);
		end
		wave = pick[mwpo_pkg::WAVE_BITS-1:0];
		case ($urandom_range(0, 4))
			0:       pick = '0;
			1:       pick = DATA_BITS'(mwpo_pkg::PAN_FULL);
			2:       pick = '1;
			3:       pick = $urandom_range(0, mwpo_pkg::PAN_FULL);
			default: pick = $urandom;
		endcase
		amp = pick[mwpo_pkg::AMP_BITS-1:0];
		case ($urandom_range(0, 4))
			0:       pick = '0;
			1:       pick = DATA_BITS'(mwpo_pkg::PAN_FULL);
			2:       pick = '1;
			3:       pick = $urandom_range(mwpo_pkg::PAN_FULL + 1, 16'hFFFF);
			default: pick = $urandom_range(0, mwpo_pkg::PAN_FULL);
		endcase
		pan = pick[mwpo_pkg::PAN_BITS-1:0];
		junk = $urandom_range(0, 1) ? DATA_BITS'($urandom) : '0;
		setup_voice(step_w,
			{junk[DATA_BITS-1:mwpo_pkg::WAVE_BITS], wave},
			{junk[DATA_BITS-1:mwpo_pkg::AMP_BITS], amp},
			{junk[DATA_BITS-1:mwpo_pkg::PAN_BITS], pan});
	endtask

	// A run of random requests; gap_odds of zero means no sender gaps.
	task automatic run_phase(input int count, input int gap_odds, input int adv_pct);
		int i;
		for (i = 0; i < count; i++) begin
			offer($urandom_range(0, 99) < adv_pct);
			if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
				pause_sender($urandom_range(1, 15));
			end
		end
	endtask

	// Receiver: random stall bursts, one long hold-off on request, none when calm.
	initial begin : receiver
		int   burst;
		logic hold_done;
		hold_done = 1'b0;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				out_stall <= 1'b1;
				hold_done = 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else if (!rx_calm && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 15);
				out_stall <= 1'b1;
				repeat (burst) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long.
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		@(posedge arst_n);
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_en) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("** multi_waveform_phase_oscillator: FAILED **");
		$finish;
	end

	// Stimulus: reset, directed cases, random phases, a clean tail, then the verdict.
	initial begin : stimulus
		int done;
		int chunk;
		int phase_no;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		advance   = 1'b0;
		cfg_en    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: requests that hold and that advance the phase.
		offer(1'b0);
		offer(1'b1);
		offer(1'b1);

		// Saw at half-turn steps: the phase wraps.
		setup_voice(32'h8000_0000, DATA_BITS'(mwpo_pkg::WAVE_SAW),
			DATA_BITS'(mwpo_pkg::PAN_FULL), '0);
		offer(1'b1);
		offer(1'b1);
		offer(1'b0);

		// Square with the largest step, gain beyond unity and pan beyond full right.
		setup_voice(32'hFFFF_FFFF, DATA_BITS'(mwpo_pkg::WAVE_SQUARE), 32'h0000_FFFF,
			32'h0000_FFFF);
		offer(1'b1);
		offer(1'b1);

		// Triangle and sine at quarter-turn steps visit every quadrant.
		setup_voice(32'h4000_0000, DATA_BITS'(mwpo_pkg::WAVE_TRIANGLE),
			DATA_BITS'(mwpo_pkg::PAN_FULL), DATA_BITS'(mwpo_pkg::PAN_FULL));
		repeat (4) offer(1'b1);
		setup_voice(32'h4000_0000, DATA_BITS'(mwpo_pkg::WAVE_SINE),
			DATA_BITS'(mwpo_pkg::PAN_FULL), '0);
		repeat (4) offer(1'b1);

		// Noise steps only on requests that advance.
		setup_voice(32'd123, DATA_BITS'(mwpo_pkg::WAVE_NOISE),
			DATA_BITS'(mwpo_pkg::PAN_FULL), DATA_BITS'(mwpo_pkg::RST_PAN));
		offer(1'b1);
		offer(1'b0);
		offer(1'b1);
		offer(1'b1);

		// Unused waveform codes give silence.
		setup_voice('0, DATA_BITS'(WAVE_UNUSED_LO), DATA_BITS'(mwpo_pkg::PAN_FULL),
			DATA_BITS'(mwpo_pkg::RST_PAN));
		offer(1'b1);
		setup_voice(32'h1234_5678, DATA_BITS'(WAVE_UNUSED_HI), 32'h0000_FFFF, '0);
		offer(1'b1);

		// Random phases; one of them holds the receiver off while the sender keeps going.
		done     = 0;
		phase_no = 0;
		while (done < RANDOM_ITEMS - CLEAN_TAIL) begin
			random_voice();
			chunk = $urandom_range(20, 80);
			if (phase_no == 2) begin
				hold_req <= 1'b1;
				run_phase(chunk, 0, 75);
			end else if (phase_no % 4 == 3) begin
				rx_calm <= 1'b1;
				run_phase(chunk, 0, $urandom_range(40, 100));
				rx_calm <= 1'b0;
			end else begin
				run_phase(chunk, 4, $urandom_range(40, 100));
			end
			done += chunk;
			phase_no++;
		end

		// Final stretch without idling on either side.
		random_voice();
		rx_calm <= 1'b1;
		run_phase(CLEAN_TAIL, 0, 75);

		wait_idle();
		if (fail_count == 0 && pairs_pending == 0) begin
			$display("** multi_waveform_phase_oscillator: PASSED **");
		end else begin
			$display("** multi_waveform_phase_oscillator: FAILED **");
		end
		$finish;
	end

endmodule
